@@ hw/rtl/sbda_pkg.sv @@
// shared constants and types of the signed binary to decimal ascii converter
package sbda_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 20;
  localparam int IN_W       = 64;
  localparam int CHAR_W     = 8;

  // decimal digits needed for 2^(VALUE_BITS-1), using log10(2) ~ 0.30103
  localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int PTR_W  = $clog2(DIGITS);
  localparam int NUM_W  = $clog2(MAX_CHARS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0]        DIGIT_HALF = 4'd5;
  localparam logic [3:0]        DIGIT_FIX  = 4'd3;

  typedef logic [DIGITS-1:0][3:0] sbda_bcd_t;

  typedef struct packed {
    logic      valid;
    logic      neg;
    sbda_bcd_t bcd;
  } sbda_conv_t;

endpackage

@@ hw/rtl/sbda_dabble.sv @@
// bit-serial shift-and-add-3 converter from magnitude to packed bcd
module sbda_dabble (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [sbda_pkg::IN_W-1:0] value_i,
  output logic                    busy_o,
  output sbda_pkg::sbda_conv_t    conv_o
);
  import sbda_pkg::*;

  logic                  active_q, active_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  sbda_bcd_t             bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  sbda_bcd_t             adj;

  assign raw = value_i[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= DIGIT_HALF) ? (bcd_q[i] + DIGIT_FIX) : bcd_q[i];
    end
  end

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    if (load_i) begin
      active_d = 1'b1;
      cnt_d    = CNT_W'(VALUE_BITS);
      bin_d    = mag;
      bcd_d    = '0;
      neg_d    = raw[VALUE_BITS-1];
    end else if (active_q) begin
      // adjusted digits shift up one bit, next magnitude bit enters at the bottom
      bcd_d = {adj[DIGITS-1][2:0], adj[DIGITS-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign busy_o       = active_q | done_q;
  assign conv_o.valid = done_q;
  assign conv_o.neg   = neg_q;
  assign conv_o.bcd   = bcd_q;

endmodule

@@ hw/rtl/sbda_emit.sv @@
// character serialiser: sign, then significant digits, one per cycle
module sbda_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sbda_pkg::sbda_conv_t          conv_i,
  output logic                          busy_o,
  output logic [sbda_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o,
  output logic                          strobe_o
);
  import sbda_pkg::*;

  logic              active_q, active_d;
  logic              sign_q, sign_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [NUM_W-1:0]  num_q, num_d;
  sbda_bcd_t         digits_q, digits_d;
  logic              strobe_q, strobe_d;
  logic              last_q, last_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [PTR_W-1:0]  msd;
  logic              is_last;

  // most significant non-zero digit, zero when the value is zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (conv_i.bcd[i] != 4'd0) msd = PTR_W'(i);
    end
  end

  assign is_last = (!sign_q && (ptr_q == '0)) || (num_q == NUM_W'(MAX_CHARS));

  always_comb begin
    active_d = active_q;
    sign_d   = sign_q;
    ptr_d    = ptr_q;
    num_d    = num_q;
    digits_d = digits_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    char_d   = char_q;
    if (conv_i.valid) begin
      active_d = 1'b1;
      sign_d   = conv_i.neg;
      ptr_d    = msd;
      num_d    = NUM_W'(1);
      digits_d = conv_i.bcd;
    end else if (active_q) begin
      strobe_d = 1'b1;
      last_d   = is_last;
      char_d   = sign_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits_q[ptr_q]});
      num_d    = num_q + 1'b1;
      if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        ptr_d = ptr_q - 1'b1;
      end
      if (is_last) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q   <= sign_d;
    ptr_q    <= ptr_d;
    num_q    <= num_d;
    digits_q <= digits_d;
    last_q   <= last_d;
    char_q   <= char_d;
  end

  assign busy_o      = active_q;
  assign strobe_o    = strobe_q;
  assign last_o      = last_q;
  assign character_o = char_q;

endmodule

@@ hw/rtl/signed_binary_to_decimal_ascii_top.sv @@
// top level of the signed binary to decimal ascii converter
//
// usage
//   a transaction is accepted on the clock edge where start is high and
//   busy is low; value_i is sampled on that edge as a 64-bit two's
//   complement number
//   the decimal text then leaves on character_o, one character per cycle,
//   each marked by strobe_o for exactly one cycle, most significant first;
//   a minus sign leads a negative value, zero gives a single '0', and
//   last_o flags the final character of the number
// flow
//   the binary to bcd step shifts one input bit per cycle, and the first
//   character appears once all input bits are shifted, the finished digits
//   have passed the hand-over register to the serialiser and its output
//   register is loaded; the further characters follow one per cycle, and
//   busy stays high until the last character is on the ports
// reset
//   rst_ni is asynchronous and active low; it drops any transaction in
//   progress, clears strobe_o and busy
// stalls
//   there is no back-pressure on the result side: every character is
//   presented for one cycle only and the receiver must take it
module signed_binary_to_decimal_ascii_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [sbda_pkg::IN_W-1:0]   value_i,
  output logic [sbda_pkg::CHAR_W-1:0] character_o,
  output logic                        last_o,
  output logic                        strobe_o
);
  import sbda_pkg::*;

  logic       accept;
  logic       dab_busy;
  logic       emit_busy;
  sbda_conv_t conv;

  // one number in flight at a time, from acceptance to its last character
  assign accept = start & ~busy;
  assign busy   = dab_busy | emit_busy;

  // magnitude and sign, then bcd digits built one input bit per cycle
  sbda_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .value_i (value_i),
    .busy_o  (dab_busy),
    .conv_o  (conv)
  );

  // sign and significant digits out as ascii, registered outputs
  sbda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .conv_i      (conv),
    .busy_o      (emit_busy),
    .character_o (character_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

endmodule

@@ hw/rtl/sbda_checker.sv @@
// port-level checks on the converter, bound to the top level
module sbda_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [sbda_pkg::CHAR_W-1:0] character_o,
  input logic                        last_o,
  input logic                        strobe_o
);
  import sbda_pkg::*;

  // every character sent is a minus sign or a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (character_o == CHAR_MINUS) ||
                 ((character_o >= CHAR_ZERO) && (character_o <= CHAR_ZERO + 8'd9)))
    else $error("character out of range");

  // a minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (character_o == CHAR_MINUS)) |-> !last_o)
    else $error("minus sign flagged last");

  // characters of one number come without gaps until last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside a number");

  // an accepted transaction makes the block busy and sends nothing at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !strobe_o))
    else $error("accept not followed by busy");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_checker u_sbda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .character_o (character_o),
  .last_o      (last_o),
  .strobe_o    (strobe_o)
);
